/* hdl/spq_pkg.sv */
// shared types and constants for the sorted priority queue
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int PRIO_W      = 16;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef struct packed {
      logic                     kind;
      logic signed [PRIO_W-1:0] priority_req;
      logic signed [DATA_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic                     head_valid;
      logic signed [PRIO_W-1:0] head_priority;
      logic signed [DATA_W-1:0] head_payload;
      logic [COUNT_W-1:0]       entry_count;
      logic                     underflow;
      logic                     overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic signed [DATA_W-1:0] data;
   } entry_type;

   typedef struct packed {
      logic      ins_en;
      logic      rem_en;
      entry_type entry;
   } cmd_type;

endpackage

/* hdl/spq_cell.sv */
// one slot of the sorted shift chain
module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               occupied,
   input  spq_pkg::entry_type left_entry,
   input  logic               left_before,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type cur_entry,
   output spq_pkg::entry_type nxt_entry,
   output logic               ahead
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // new entry sorts ahead of this slot; equal priority stays behind
   assign ahead = !occupied || (cmd.entry.prio < entry_ff.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_en && ahead) begin
         entry_in = left_before ? left_entry : cmd.entry;
      end else if (cmd.rem_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cur_entry = entry_ff;
   assign nxt_entry = entry_in;

endmodule

/* hdl/sorted_priority_queue_core.sv */
// sorted priority queue: request/response channels around a chain of sorted slots
//
// each request is an insert (kind 0) of a priority and payload, or a removal
// of the head (kind 1); every request yields exactly one response carrying
// the head entry, the entry count and the underflow and overflow flags
// after that request. lower priority numbers are served first, and equal
// priorities leave in arrival order.
// the response is registered and appears in the cycle after its request is
// taken; one request is taken per cycle while the response is not stalled,
// as every slot compares against the new priority and shifts in parallel.
// the response sits in an output register; a new request is taken while
// that register is empty or being drained in the same cycle, so a stalled
// receiver holds req_ready low only until the waiting response is taken.
// an insert into a full queue is dropped with overflow set; a removal from
// an empty queue sets underflow and reports zero head fields.
// reset empties the queue and the output register; slot contents are left
// as they are and are never read before being written.
module sorted_priority_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   logic [spq_pkg::CNT_W-1:0] count_ff;
   logic [spq_pkg::CNT_W-1:0] count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   spq_pkg::rsp_type          rsp_data_ff;
   spq_pkg::rsp_type          rsp_data_in;

   logic             accept;
   logic             is_full;
   logic             is_empty;
   spq_pkg::cmd_type cmd;

   spq_pkg::entry_type cur_entry [spq_pkg::QUEUE_DEPTH];
   spq_pkg::entry_type nxt_entry [spq_pkg::QUEUE_DEPTH];
   logic               ahead     [spq_pkg::QUEUE_DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      cmd.ins_en     = accept && (req_data.kind == spq_pkg::KIND_INSERT) && !is_full;
      cmd.rem_en     = accept && (req_data.kind == spq_pkg::KIND_REMOVE) && !is_empty;
      cmd.entry.prio = req_data.priority_req;
      cmd.entry.data = req_data.payload;
   end

   genvar i;
   generate
      for (i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : g_cell
         spq_pkg::entry_type left_entry;
         spq_pkg::entry_type right_entry;
         logic               left_before;
         logic               occupied;

         assign occupied = (spq_pkg::CNT_W'(i) < count_ff);

         if (i == 0) begin : g_first
            assign left_entry  = cmd.entry;
            assign left_before = 1'b0;
         end else begin : g_inner
            assign left_entry  = cur_entry[i-1];
            assign left_before = ahead[i-1];
         end

         if (i == spq_pkg::QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = cur_entry[i];
         end else begin : g_mid
            assign right_entry = cur_entry[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .occupied    (occupied),
            .left_entry  (left_entry),
            .left_before (left_before),
            .right_entry (right_entry),
            .cur_entry   (cur_entry[i]),
            .nxt_entry   (nxt_entry[i]),
            .ahead       (ahead[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (cmd.ins_en) begin
         count_in = count_ff + spq_pkg::CNT_W'(1);
      end else if (cmd.rem_en) begin
         count_in = count_ff - spq_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_data_in             = rsp_data_ff;
      rsp_data_in.head_valid  = (count_in != '0);
      rsp_data_in.entry_count = spq_pkg::COUNT_W'(count_in);
      rsp_data_in.underflow   = (req_data.kind == spq_pkg::KIND_REMOVE) && is_empty;
      rsp_data_in.overflow    = (req_data.kind == spq_pkg::KIND_INSERT) && is_full;
      if (count_in != '0) begin
         rsp_data_in.head_priority = nxt_entry[0].prio;
         rsp_data_in.head_payload  = nxt_entry[0].data;
      end else begin
         rsp_data_in.head_priority = '0;
         rsp_data_in.head_payload  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/spq_checker.sv */
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input spq_pkg::rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.head_valid == (rsp_data.entry_count != '0)))
      else $error("head valid disagrees with count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.head_valid |->
         (rsp_data.head_priority == '0) && (rsp_data.head_payload == '0))
      else $error("empty queue reports nonzero head");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.underflow && rsp_data.overflow))
      else $error("underflow and overflow together");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.underflow |-> (rsp_data.entry_count == '0))
      else $error("underflow with entries held");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
